// ===== sv/jipa_pkg.sv =====
// shared constants, codes and types of the jet image pixel accumulator
package jipa_pkg;

    // field widths
    localparam int PT_W    = 20;
    localparam int COORD_W = 16;
    localparam int ADDR_W  = 16;
    localparam int SIDE_W  = 9;
    localparam int VALUE_W = 20;
    localparam int REQ_W   = 2;

    // defaults and fixed image limits
    localparam int SUM_WIDTH_DEF = 20;
    localparam int MAX_SIDE      = 256;
    localparam int MIN_SIDE      = 2;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd224;

    // fixed point: q4.12 coordinates
    localparam int FRAC_SHIFT = 16;
    localparam int Q_ONE      = 4096;
    localparam int Q_PI       = 12868;
    localparam int Q_TWO_PI   = 2 * Q_PI;
    localparam int IDX_SHIFT  = 13;

    localparam logic [31:0] VALUE_MAX = 32'h000F_FFFF;

    // request codes
    localparam logic [REQ_W-1:0] REQ_NEW_JET = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEPOSIT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

    // control from the sequencer to the pixel store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } store_ctl_t;

endpackage

// ===== sv/jipa_ifs.sv =====
// valid/ready channel interfaces for requests and pixel results

interface jipa_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [jipa_pkg::REQ_W-1:0]            req_type;
    logic [jipa_pkg::PT_W-1:0]             momentum;
    logic signed [jipa_pkg::COORD_W-1:0]   pseudorapidity;
    logic signed [jipa_pkg::COORD_W-1:0]   azimuth;
    logic [jipa_pkg::ADDR_W-1:0]           pixel_addr;

    modport source (
        output valid, req_type, momentum, pseudorapidity, azimuth, pixel_addr,
        input  ready
    );
    modport sink (
        input  valid, req_type, momentum, pseudorapidity, azimuth, pixel_addr,
        output ready
    );
endinterface

interface jipa_pix_if;
    logic                          valid;
    logic                          ready;
    logic [jipa_pkg::VALUE_W-1:0]  pixel_value;
    logic                          pixel_saturated;

    modport source (
        output valid, pixel_value, pixel_saturated,
        input  ready
    );
    modport sink (
        input  valid, pixel_value, pixel_saturated,
        output ready
    );
endinterface

// ===== sv/jipa_div.sv =====
// iterative radix-2 divider for the momentum fraction pt * 2^16 / jet pt
module jipa_div #(
    parameter int SUM_WIDTH = jipa_pkg::SUM_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [jipa_pkg::PT_W-1:0]     pt,
    input  logic [jipa_pkg::PT_W-1:0]     ref_pt,
    output logic                          busy,
    output logic [SUM_WIDTH-1:0]          quotient
);

    localparam int DVD_W = jipa_pkg::PT_W + jipa_pkg::FRAC_SHIFT;
    localparam int CNT_W = $clog2(SUM_WIDTH + 1);
    localparam int PT_W  = jipa_pkg::PT_W;

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [PT_W-1:0]       rem_reg, rem_next;
    logic [SUM_WIDTH-1:0]  low_reg, low_next;
    logic [SUM_WIDTH-1:0]  quo_reg, quo_next;
    logic                  sat_reg, sat_next;

    logic [DVD_W-1:0]      dividend_w;
    logic [DVD_W-1:0]      high_w;
    logic                  sat_w;
    logic [PT_W:0]         trial_w;
    logic [PT_W:0]         diff_w;
    logic                  ge_w;

    // quotient of 2^SUM_WIDTH or more iff the part above the low bits reaches the divisor
    assign dividend_w = {pt, {jipa_pkg::FRAC_SHIFT{1'b0}}};
    assign high_w     = dividend_w >> SUM_WIDTH;
    assign sat_w      = (ref_pt == '0) || (high_w >= DVD_W'(ref_pt));

    assign trial_w = {rem_reg, low_reg[SUM_WIDTH-1]};
    assign diff_w  = trial_w - {1'b0, ref_pt};
    assign ge_w    = trial_w >= {1'b0, ref_pt};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        sat_next  = sat_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(SUM_WIDTH);
            rem_next  = high_w[PT_W-1:0];
            low_next  = dividend_w[SUM_WIDTH-1:0];
            quo_next  = '0;
            sat_next  = sat_w;
        end
        else if (busy_reg)
        begin
            rem_next  = ge_w ? diff_w[PT_W-1:0] : trial_w[PT_W-1:0];
            low_next  = low_reg << 1;
            quo_next  = {quo_reg[SUM_WIDTH-2:0], ge_w};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        sat_reg <= sat_next;
    end

    assign busy     = busy_reg;
    assign quotient = sat_reg ? {SUM_WIDTH{1'b1}} : quo_reg;

endmodule

// ===== sv/jipa_store.sv =====
// pixel store: sum and saturation mark per pixel, one write and one registered read port
module jipa_store #(
    parameter int SUM_WIDTH = jipa_pkg::SUM_WIDTH_DEF
) (
    input  logic                   clk,
    input  jipa_pkg::store_ctl_t   ctl,
    input  logic [SUM_WIDTH:0]     wr_data,
    output logic [SUM_WIDTH:0]     rd_data
);

    localparam int DEPTH = 1 << jipa_pkg::ADDR_W;

    // bit SUM_WIDTH is the saturation mark
    logic [SUM_WIDTH:0] mem [DEPTH];
    logic [SUM_WIDTH:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= wr_data;
        end
        if (ctl.re)
        begin
            rd_data_reg <= mem[ctl.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/jet_image_pixel_accumulator_top.sv =====
// jet image pixel accumulator: sequencer, shared index multiplier, divider and pixel store
// deposit: S_MUL_ETA, S_MUL_PHI, S_MUL_ADDR, S_ADDR, then S_DIV_WAIT for the fraction divider;
//   read: S_RD_OUT to the output register; dropped particle or unknown request: stays idle
// new jet: clear sweep of the whole 65536-entry store, one pixel a cycle
// throughput: one item at a time, next item taken when the previous one leaves the sequencer
// reset: async active low; a clear sweep of the whole store follows reset, no request taken meanwhile
// the configuration register is writable at all times, including during the sweep
module jet_image_pixel_accumulator_top #(
    parameter int SUM_WIDTH = jipa_pkg::SUM_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [jipa_pkg::SIDE_W-1:0]    cfg_wr_data,
    jipa_req_if.sink                       req,
    jipa_pix_if.source                     pix
);

    localparam int PT_W   = jipa_pkg::PT_W;
    localparam int ADDR_W = jipa_pkg::ADDR_W;
    localparam int SIDE_W = jipa_pkg::SIDE_W;
    localparam int OFF_W  = 14;
    localparam int PROD_W = OFF_W + SIDE_W;
    localparam int IDX_W  = 8;

    localparam logic signed [16:0] ETA_LIM    = 17'(jipa_pkg::Q_ONE);
    localparam logic signed [17:0] PHI_LIM    = 18'(jipa_pkg::Q_ONE);
    localparam logic signed [17:0] PHI_PI     = 18'(jipa_pkg::Q_PI);
    localparam logic signed [17:0] PHI_TWO_PI = 18'(jipa_pkg::Q_TWO_PI);
    localparam logic [SIDE_W-1:0]  SIDE_LO    = SIDE_W'(jipa_pkg::MIN_SIDE);
    localparam logic [SIDE_W-1:0]  SIDE_HI    = SIDE_W'(jipa_pkg::MAX_SIDE);
    localparam logic [SUM_WIDTH-1:0] SUM_TOP  = {SUM_WIDTH{1'b1}};

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_CLEAR    = 8'b0000_0010,
        S_MUL_ETA  = 8'b0000_0100,
        S_MUL_PHI  = 8'b0000_1000,
        S_MUL_ADDR = 8'b0001_0000,
        S_ADDR     = 8'b0010_0000,
        S_DIV_WAIT = 8'b0100_0000,
        S_RD_OUT   = 8'b1000_0000
    } state_t;

    // phi difference folded into [-pi, pi)
    function automatic logic signed [17:0] wrap_phi(input logic signed [17:0] d);
        logic signed [17:0] v;
        v = d;
        for (int k = 0; k < 4; k++)
        begin
            if (v >= PHI_PI)
            begin
                v = v - PHI_TWO_PI;
            end
            else if (v < -PHI_PI)
            begin
                v = v + PHI_TWO_PI;
            end
        end
        return v;
    endfunction

    // control state
    state_t                        state_reg, state_next;
    logic [ADDR_W-1:0]             clr_cnt_reg, clr_cnt_next;
    logic [SIDE_W-1:0]             side_reg, side_next;
    logic [PT_W-1:0]               ref_m_reg, ref_m_next;
    logic signed [15:0]            ref_eta_reg, ref_eta_next;
    logic signed [15:0]            ref_phi_reg, ref_phi_next;
    logic                          out_valid_reg, out_valid_next;

    // payload
    logic [OFF_W-1:0]              off_eta_reg, off_eta_next;
    logic [OFF_W-1:0]              off_phi_reg, off_phi_next;
    logic [IDX_W-1:0]              ieta_reg, ieta_next;
    logic [IDX_W-1:0]              iphi_reg, iphi_next;
    logic [ADDR_W-1:0]             addr_reg, addr_next;
    logic [PROD_W-1:0]             mul_p_reg, mul_p_next;
    logic [jipa_pkg::VALUE_W-1:0]  out_value_reg, out_value_next;
    logic                          out_sat_reg, out_sat_next;

    // datapath wires
    logic signed [16:0]            deta_w;
    logic signed [16:0]            deta_off_w;
    logic signed [17:0]            dphi_raw_w;
    logic signed [17:0]            dphi_w;
    logic signed [17:0]            dphi_off_w;
    logic                          in_range_w;
    logic [SIDE_W-1:0]             side_eff_w;
    logic [SIDE_W-1:0]             side_m1_w;
    logic [OFF_W-1:0]              mul_a_w;
    logic [SIDE_W:0]               idx_raw_w;
    logic [IDX_W-1:0]              idx_w;
    logic [ADDR_W-1:0]             addr_sum_w;

    jipa_pkg::store_ctl_t          st_ctl;
    logic [SUM_WIDTH:0]            st_wr_data;
    logic [SUM_WIDTH:0]            st_rd_data;
    logic [SUM_WIDTH-1:0]          old_sum_w;
    logic [SUM_WIDTH:0]            new_sum_w;
    logic [SUM_WIDTH:0]            upd_w;
    logic [31:0]                   sum_ext_w;

    logic                          div_start;
    logic                          div_busy;
    logic [SUM_WIDTH-1:0]          frac_w;

    // coordinate differences against the stored jet axis
    assign deta_w     = 17'(req.pseudorapidity) - 17'(ref_eta_reg);
    assign dphi_raw_w = 18'(req.azimuth) - 18'(ref_phi_reg);
    assign dphi_w     = wrap_phi(dphi_raw_w);
    assign in_range_w = (deta_w >= -ETA_LIM) && (deta_w <= ETA_LIM)
                     && (dphi_w >= -PHI_LIM) && (dphi_w <= PHI_LIM);
    assign deta_off_w = deta_w + ETA_LIM;
    assign dphi_off_w = dphi_w + PHI_LIM;

    // image side held to its legal range
    always_comb
    begin
        priority if (side_reg < SIDE_LO)
        begin
            side_eff_w = SIDE_LO;
        end
        else if (side_reg > SIDE_HI)
        begin
            side_eff_w = SIDE_HI;
        end
        else
        begin
            side_eff_w = side_reg;
        end
    end
    assign side_m1_w = side_eff_w - SIDE_W'(1);

    // shared multiplier: offset times side for both indices, then row times side
    assign mul_p_next = PROD_W'(mul_a_w) * PROD_W'(side_eff_w);
    assign idx_raw_w  = mul_p_reg[PROD_W-1:jipa_pkg::IDX_SHIFT];
    assign idx_w      = (idx_raw_w > {1'b0, side_m1_w}) ? side_m1_w[IDX_W-1:0]
                                                       : idx_raw_w[IDX_W-1:0];
    assign addr_sum_w = mul_p_reg[ADDR_W-1:0] + ADDR_W'(iphi_reg);

    // read-modify-write of one pixel, saturating at the top code
    assign old_sum_w = st_rd_data[SUM_WIDTH-1:0];
    assign new_sum_w = {1'b0, old_sum_w} + {1'b0, frac_w};
    assign upd_w     = (new_sum_w >= {1'b0, SUM_TOP}) ? {1'b1, SUM_TOP}
                                                    : {st_rd_data[SUM_WIDTH],
                                                       new_sum_w[SUM_WIDTH-1:0]};
    assign sum_ext_w = 32'(old_sum_w);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        side_next      = cfg_wr_en ? cfg_wr_data : side_reg;
        ref_m_next     = ref_m_reg;
        ref_eta_next   = ref_eta_reg;
        ref_phi_next   = ref_phi_reg;
        out_valid_next = out_valid_reg && !pix.ready;
        off_eta_next   = off_eta_reg;
        off_phi_next   = off_phi_reg;
        ieta_next      = ieta_reg;
        iphi_next      = iphi_reg;
        addr_next      = addr_reg;
        out_value_next = out_value_reg;
        out_sat_next   = out_sat_reg;
        mul_a_w        = '0;
        div_start      = 1'b0;
        st_ctl         = '0;
        st_wr_data     = '0;
        req.ready      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    unique case (req.req_type)
                        jipa_pkg::REQ_NEW_JET:
                        begin
                            ref_m_next   = req.momentum;
                            ref_eta_next = req.pseudorapidity;
                            ref_phi_next = req.azimuth;
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        jipa_pkg::REQ_DEPOSIT:
                        begin
                            // a particle outside the window leaves no trace
                            if (in_range_w)
                            begin
                                div_start    = 1'b1;
                                off_eta_next = deta_off_w[OFF_W-1:0];
                                off_phi_next = dphi_off_w[OFF_W-1:0];
                                state_next   = S_MUL_ETA;
                            end
                        end
                        jipa_pkg::REQ_READ:
                        begin
                            st_ctl.re    = 1'b1;
                            st_ctl.raddr = req.pixel_addr;
                            state_next   = S_RD_OUT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                st_ctl.we    = 1'b1;
                st_ctl.waddr = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == {ADDR_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL_ETA:
            begin
                mul_a_w    = off_eta_reg;
                state_next = S_MUL_PHI;
            end
            S_MUL_PHI:
            begin
                mul_a_w    = off_phi_reg;
                ieta_next  = idx_w;
                state_next = S_MUL_ADDR;
            end
            S_MUL_ADDR:
            begin
                mul_a_w    = OFF_W'(ieta_reg);
                iphi_next  = idx_w;
                state_next = S_ADDR;
            end
            S_ADDR:
            begin
                st_ctl.re    = 1'b1;
                st_ctl.raddr = addr_sum_w;
                addr_next    = addr_sum_w;
                state_next   = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (!div_busy)
                begin
                    st_ctl.we    = 1'b1;
                    st_ctl.waddr = addr_reg;
                    st_wr_data   = upd_w;
                    state_next   = S_IDLE;
                end
            end
            S_RD_OUT:
            begin
                // wait for the output register to drain
                if (!out_valid_reg || pix.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = (sum_ext_w > jipa_pkg::VALUE_MAX)
                                   ? jipa_pkg::VALUE_MAX[jipa_pkg::VALUE_W-1:0]
                                   : sum_ext_w[jipa_pkg::VALUE_W-1:0];
                    out_sat_next   = st_rd_data[SUM_WIDTH];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            side_reg      <= jipa_pkg::SIDE_RESET;
            ref_m_reg     <= '0;
            ref_eta_reg   <= '0;
            ref_phi_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            side_reg      <= side_next;
            ref_m_reg     <= ref_m_next;
            ref_eta_reg   <= ref_eta_next;
            ref_phi_reg   <= ref_phi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_eta_reg   <= off_eta_next;
        off_phi_reg   <= off_phi_next;
        ieta_reg      <= ieta_next;
        iphi_reg      <= iphi_next;
        addr_reg      <= addr_next;
        mul_p_reg     <= mul_p_next;
        out_value_reg <= out_value_next;
        out_sat_reg   <= out_sat_next;
    end

    jipa_div #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .pt       (req.momentum),
        .ref_pt   (ref_m_reg),
        .busy     (div_busy),
        .quotient (frac_w)
    );

    jipa_store #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_store (
        .clk     (clk),
        .ctl     (st_ctl),
        .wr_data (st_wr_data),
        .rd_data (st_rd_data)
    );

    assign pix.valid           = out_valid_reg;
    assign pix.pixel_value     = out_value_reg;
    assign pix.pixel_saturated = out_sat_reg;

`ifndef SYNTH
    // the store port never reads and writes in the same cycle
    a_store_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(st_ctl.we && st_ctl.re))
        else $error("pixel store read and write collide");

    // divider is finished whenever the sequencer can take a new item
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_busy)
        else $error("divider busy while sequencer idle");

    // a new-jet transfer starts the clear sweep from the first pixel
    a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.req_type == jipa_pkg::REQ_NEW_JET)
        |=> (state_reg == S_CLEAR && clr_cnt_reg == '0))
        else $error("new jet did not start the clear sweep");

    // a read transfer issues the store read at once
    a_read_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.req_type == jipa_pkg::REQ_READ)
        |-> (st_ctl.re && st_ctl.raddr == req.pixel_addr))
        else $error("read transfer without store read");
`endif

endmodule
